>>> src/bdbc_pkg.sv
// Shared types and constants for the blob centroid finder.
`default_nettype none
package bdbc_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_BITS       = 10;
  localparam int CLUSTER_SPAN_DEF = 20;

  localparam int OUT_BITS   = 13;
  localparam int CNT_BITS   = 21;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 14;
  localparam logic [CNT_BITS-1:0] COUNT_LIMIT = 21'd1048576;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 13'd8191;

  // quotient output width of the shared divider
  localparam int QUO_BITS = 14;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESH  = 3'd0,
    REG_CROW    = 3'd1,
    REG_CCOL    = 3'd2,
    REG_RADIUS  = 3'd3,
    REG_SHEIGHT = 3'd4,
    REG_SWIDTH  = 3'd5,
    REG_MHEIGHT = 3'd6,
    REG_MWIDTH  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_SCAN,
    ST_JOIN,
    ST_OPEN,
    ST_EMIT_SCAN,
    ST_EMIT_ROW,
    ST_EMIT_COL,
    ST_EMIT_OUT,
    ST_CLEAR
  } state_t;

endpackage
`default_nettype wire

>>> src/bdbc_div.sv
// Shared restoring divider: computes round(num/den) with halves up, one bit a cycle.
`default_nettype none
module bdbc_div
  import bdbc_pkg::*;
#(
  parameter int NUM_BITS = 46,
  parameter int DEN_BITS = 33
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     busy,
  output logic                     done,
  output logic [QUO_BITS-1:0]      quo
);
  // computes (2*num + den) / (2*den): with quotients >= 2^QUO_BITS saturated
  localparam int NB = NUM_BITS + 2;
  localparam int DB = DEN_BITS + 1;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] n_sh;
  logic [DB:0]   rem;
  logic [DB-1:0] d2;
  logic [NB-1:0] q;
  logic [CW-1:0] cnt;
  logic [DB:0]   trial;
  logic [DB+1:0] sub;

  assign trial = {rem[DB-1:0], n_sh[NB-1]};
  assign sub   = {1'b0, trial} - {2'b0, d2};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NB);
        n_sh <= ({2'b0, num} << 1) + NB'(den);
        d2   <= {den, 1'b0};
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        n_sh <= n_sh << 1;
        if (!sub[DB+1]) begin
          rem <= sub[DB:0];
          q   <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // a zero divisor gives zero
  always_comb begin
    if (d2 == '0) quo = '0;
    else if (|q[NB-1:QUO_BITS]) quo = '1;
    else quo = q[QUO_BITS-1:0];
  end
endmodule
`default_nettype wire

>>> src/bdbc_mul.sv
// Shared multiplier with registered product, used for radius test and scaling.
`default_nettype none
module bdbc_mul #(
  parameter int A_BITS = 32,
  parameter int B_BITS = 14
) (
  input  wire logic                     clk,
  input  wire logic [A_BITS-1:0]        a,
  input  wire logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0]      p
);
  always_ff @(posedge clk) begin
    p <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
  end
endmodule
`default_nettype wire

>>> src/background_diff_blob_centroid.sv
// Top level: pixel classification, cluster table sequencer and centroid output.
//
// Channel   | Dir | Word
// s_axis_*  | in  | tdata: row, col, cur r/g/b, bg r/g/b (68 bits, padded to 72); tlast = eof
// m_axis_*  | out | tdata: centroid_row, centroid_col, member_count (47 bits, padded to 48);
//           |     | tuser: none_found, overflow; tlast = last
// cfg_*     | in  | register write, index 0..7
//
// A changed pixel inside the window and the radius also scans the cluster table entry by
// entry until a hit or the last entry. At frame end each cluster costs two divisions (two
// multiplies, then one quotient bit a cycle through the shared divider), plus the table scan
// and the handshake.
// rst is synchronous; it clears the valid bits and the overflow flag at once.
// s_axis_tready is low from acceptance until the pixel (and any frame flush) is done.
`default_nettype none
module background_diff_blob_centroid
  import bdbc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int CLUSTER_SPAN = CLUSTER_SPAN_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // row, col, cur_red, cur_green, cur_blue, bg_red, bg_green, bg_blue (low bit up)
  input  wire logic [((2*COORD_BITS+48+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                     s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // centroid_row, centroid_col, member_count (low bit up), zero padded
  output logic [47:0]                   m_axis_tdata,
  // none_found, overflow (low bit up)
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
  localparam int IDX_BITS = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int SUM_BITS = COORD_BITS + CNT_BITS;
  localparam int MA_BITS  = (SUM_BITS > 24) ? SUM_BITS : 24;
  localparam int MB_BITS  = 14;
  localparam int P_BITS   = MA_BITS + MB_BITS;
  localparam int DEN_BITS = CNT_BITS + 11;

  // configuration
  logic [7:0]  thresh;
  logic [9:0]  crow, ccol;
  logic [10:0] rad, sheight, swidth;
  logic [13:0] mheight, mwidth;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= 8'd30; crow <= '0; ccol <= '0; rad <= 11'd2047;
      sheight <= 11'd1024; swidth <= 11'd1024;
      mheight <= 14'd1024; mwidth <= 14'd1024;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESH:  thresh  <= cfg_data[7:0];
        REG_CROW:    crow    <= cfg_data[9:0];
        REG_CCOL:    ccol    <= cfg_data[9:0];
        REG_RADIUS:  rad     <= cfg_data[10:0];
        REG_SHEIGHT: sheight <= cfg_data[10:0];
        REG_SWIDTH:  swidth  <= cfg_data[10:0];
        REG_MHEIGHT: mheight <= cfg_data[13:0];
        REG_MWIDTH:  mwidth  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // cluster table
  logic [MAX_CLUSTERS-1:0] cvalid;
  logic [COORD_BITS-1:0]   anc_r [MAX_CLUSTERS];
  logic [COORD_BITS-1:0]   anc_c [MAX_CLUSTERS];
  logic [SUM_BITS-1:0]     sum_r [MAX_CLUSTERS];
  logic [SUM_BITS-1:0]     sum_c [MAX_CLUSTERS];
  logic [CNT_BITS-1:0]     pcnt  [MAX_CLUSTERS];
  logic                    ovf;

  // latched pixel
  logic [COORD_BITS-1:0] px_r, px_c;
  logic                  px_eof, px_chg, px_in;
  logic [7:0] cr, cg, cb, br, bgg, bb;

  state_t state, state_next;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] free_idx;
  logic [2:0]          step;
  logic [P_BITS-1:0]   acc;

  // shared multiplier
  logic [MA_BITS-1:0] ma;
  logic [MB_BITS-1:0] mb;
  logic [P_BITS-1:0]  mp;
  bdbc_mul #(.A_BITS(MA_BITS), .B_BITS(MB_BITS)) u_mul (.clk, .a(ma), .b(mb), .p(mp));

  // shared divider
  logic                div_start, div_busy, div_done;
  logic [P_BITS-1:0]   dnum;
  logic [DEN_BITS-1:0] dden;
  logic [QUO_BITS-1:0] dquo;
  bdbc_div #(.NUM_BITS(P_BITS), .DEN_BITS(DEN_BITS)) u_div (
    .clk, .rst, .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .done(div_done), .quo(dquo));

  logic [COORD_BITS-1:0] dr, dc;
  assign dr = (px_r > crow[COORD_BITS-1:0]) ? px_r - crow[COORD_BITS-1:0]
                                            : crow[COORD_BITS-1:0] - px_r;
  assign dc = (px_c > ccol[COORD_BITS-1:0]) ? px_c - ccol[COORD_BITS-1:0]
                                            : ccol[COORD_BITS-1:0] - px_c;

  function automatic logic chg(input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] t);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return d > t;
  endfunction

  // multiplier operand select: steps of the radius test, then scaling
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == ST_TEST) begin
      case (step)
        3'd0: begin ma = MA_BITS'(dr);  mb = MB_BITS'(dr); end
        3'd1: begin ma = MA_BITS'(dc);  mb = MB_BITS'(dc); end
        default: begin ma = MA_BITS'(rad); mb = MB_BITS'(rad); end
      endcase
    end else if (state == ST_EMIT_ROW) begin
      ma = MA_BITS'(sum_r[idx]); mb = mheight;
      if (step == 3'd1) begin ma = MA_BITS'(pcnt[idx]); mb = MB_BITS'(sheight); end
    end else if (state == ST_EMIT_COL) begin
      ma = MA_BITS'(sum_c[idx]); mb = mwidth;
      if (step == 3'd1) begin ma = MA_BITS'(pcnt[idx]); mb = MB_BITS'(swidth); end
    end
  end

  logic hit;
  assign hit = cvalid[idx]
    && (((px_r > anc_r[idx]) ? px_r - anc_r[idx] : anc_r[idx] - px_r) <= COORD_BITS'(CLUSTER_SPAN))
    && (((px_c > anc_c[idx]) ? px_c - anc_c[idx] : anc_c[idx] - px_c) <= COORD_BITS'(CLUSTER_SPAN));
  logic last_idx;
  assign last_idx = (idx == IDX_BITS'(MAX_CLUSTERS - 1));
  logic any_after;
  always_comb begin
    any_after = 1'b0;
    for (int k = 0; k < MAX_CLUSTERS; k++)
      if (k > int'(idx) && cvalid[k]) any_after = 1'b1;
  end

  // lowest free table entry
  always_comb begin
    free_idx = '0;
    for (int k = MAX_CLUSTERS - 1; k >= 0; k--)
      if (!cvalid[k]) free_idx = IDX_BITS'(k);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_TEST;
      ST_TEST: if (step == 3'd4)
                 state_next = (px_in && px_chg && acc[P_BITS-1:0] <= mp) ? ST_SCAN
                            : (px_eof ? ST_EMIT_SCAN : ST_IDLE);
      ST_SCAN: if (hit) state_next = ST_JOIN;
               else if (last_idx) state_next = ST_OPEN;
      ST_JOIN, ST_OPEN: state_next = px_eof ? ST_EMIT_SCAN : ST_IDLE;
      ST_EMIT_SCAN: if (~|cvalid) state_next = ST_EMIT_OUT;
                    else if (cvalid[idx]) state_next = ST_EMIT_ROW;
      ST_EMIT_ROW: if (div_done) state_next = ST_EMIT_COL;
      ST_EMIT_COL: if (div_done) state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: if (m_axis_tready)
                     state_next = m_axis_tlast ? ST_CLEAR : ST_EMIT_SCAN;
      ST_CLEAR: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !rst;
    m_axis_tvalid = (state == ST_EMIT_OUT);
    div_start = ((state == ST_EMIT_ROW) || (state == ST_EMIT_COL))
                && (step == 3'd2) && !div_busy;
  end

  logic [OUT_BITS-1:0] res_r, res_c;
  logic nf;
  assign m_axis_tdata = {1'b0, pcnt[idx] & {CNT_BITS{~nf}}, res_c, res_r} ;
  assign m_axis_tuser = {ovf, nf};
  assign m_axis_tlast = nf || !any_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cvalid <= '0;
      ovf <= 1'b0;
      idx <= '0;
      step <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          px_r <= s_axis_tdata[COORD_BITS-1:0];
          px_c <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
          {bb, bgg, br, cb, cg, cr} <= s_axis_tdata[2*COORD_BITS+47:2*COORD_BITS];
          px_eof <= s_axis_tlast;
          step <= '0;
          idx <= '0;
        end
        ST_TEST: begin
          step <= step + 3'd1;
          px_in <= ({1'b0, px_r} < sheight) && ({1'b0, px_c} < swidth);
          px_chg <= chg(cr, br, thresh) || chg(cg, bgg, thresh) || chg(cb, bb, thresh);
          // products arrive in the cycle after their operands
          if (step == 3'd1) acc <= mp;
          if (step == 3'd2) acc <= acc + mp;
          if (step == 3'd4) idx <= '0;
        end
        ST_SCAN: if (hit) begin
          // idx holds
        end else if (!last_idx) idx <= idx + 1'b1;
        ST_JOIN: begin
          if (pcnt[idx] >= COUNT_LIMIT) ovf <= 1'b1;
          else begin
            sum_r[idx] <= sum_r[idx] + SUM_BITS'(px_r);
            sum_c[idx] <= sum_c[idx] + SUM_BITS'(px_c);
            pcnt[idx]  <= pcnt[idx] + 1'b1;
          end
          idx <= '0;
        end
        ST_OPEN: begin
          if (&cvalid) ovf <= 1'b1;
          else begin
            cvalid[free_idx] <= 1'b1;
            anc_r[free_idx] <= px_r; anc_c[free_idx] <= px_c;
            sum_r[free_idx] <= SUM_BITS'(px_r); sum_c[free_idx] <= SUM_BITS'(px_c);
            pcnt[free_idx] <= CNT_BITS'(1);
          end
          idx <= '0;
        end
        ST_EMIT_SCAN: begin
          step <= '0;
          nf <= ~|cvalid;
          if (~|cvalid) begin
            res_r <= '0; res_c <= '0;
          end else if (!cvalid[idx]) idx <= idx + 1'b1;
        end
        ST_EMIT_ROW, ST_EMIT_COL: begin
          if (step < 3'd3) step <= step + 3'd1;
          if (step == 3'd1) acc <= mp;
          if (div_done) begin
            step <= '0;
            if (state == ST_EMIT_ROW)
              res_r <= (|dquo[QUO_BITS-1:OUT_BITS]) ? OUT_MAX : dquo[OUT_BITS-1:0];
            else
              res_c <= (|dquo[QUO_BITS-1:OUT_BITS]) ? OUT_MAX : dquo[OUT_BITS-1:0];
          end
        end
        ST_EMIT_OUT: if (m_axis_tready && !m_axis_tlast) idx <= idx + 1'b1;
        ST_CLEAR: begin
          cvalid <= '0;
          ovf <= 1'b0;
          idx <= '0;
        end
        default: ;
      endcase
    end
  end

  assign dnum = acc;
  assign dden = DEN_BITS'(mp);

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (cvalid == '0 && !ovf)) else $error("table not cleared");
  a_nf_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast) else $error("none_found not last");
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted");
endmodule
`default_nettype wire
